// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the histogram RTL modules.
// No dependencies; every macro clocks on a rising edge and is disabled in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error(msg);

// Check that a trigger is followed in the next cycle by a condition.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/mrch_pkg.sv =====
// Shared types, constants and helpers for the masked region color histogram.
// No dependencies; used by mrch_ctrl, mrch_dp and the top level.
`default_nettype none

package mrch_pkg;

  localparam int NUM_BINS       = 512;
  localparam int BIN_W          = $clog2(NUM_BINS);
  localparam int CH_W           = 8;
  localparam int CH_KEEP        = 3;     // bits of each channel kept after >> 5
  localparam int REQ_W          = 2;
  localparam int IN_FIELDS_W    = 4 * CH_W + BIN_W;
  localparam int IN_TDATA_W     = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int BIN_COUNT_W    = 16;
  localparam int OUT_TDATA_W    = BIN_COUNT_W;
  localparam int COUNT_BITS_DEF = 16;
  localparam int MAX_DIM_DEF    = 4096;

  localparam int CFG_ADDR_W     = 3;
  localparam int IMG_W_W        = 13;
  localparam int REG_W          = 12;
  localparam int CFG_DATA_W     = IMG_W_W;

  localparam logic [IMG_W_W-1:0] IMG_W_RESET  = IMG_W_W'(640);
  localparam logic [REG_W-1:0]   REGION_RESET = REG_W'(4095);

  // Register indexes of the configuration port
  localparam logic [CFG_ADDR_W-1:0] CFG_IMAGE_WIDTH   = CFG_ADDR_W'(0);
  localparam logic [CFG_ADDR_W-1:0] CFG_REGION_X      = CFG_ADDR_W'(1);
  localparam logic [CFG_ADDR_W-1:0] CFG_REGION_Y      = CFG_ADDR_W'(2);
  localparam logic [CFG_ADDR_W-1:0] CFG_REGION_WIDTH  = CFG_ADDR_W'(3);
  localparam logic [CFG_ADDR_W-1:0] CFG_REGION_HEIGHT = CFG_ADDR_W'(4);

  typedef enum logic [REQ_W-1:0] {
    REQ_START = 2'd0,
    REQ_PIXEL = 2'd1,
    REQ_READ  = 2'd2,
    REQ_NOP   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    RES_ZERO,
    RES_PIXEL,
    RES_READ
  } res_sel_t;

  // Controller to datapath
  typedef struct packed {
    logic     load_item;   // latch item fields and issue the bin read
    logic     pos_clr;     // zero the raster position
    logic     clr_step;    // write zero at the sweep address and advance
    logic     pix_commit;  // write back a hit and advance the raster position
    logic     out_load;    // load the result register
    res_sel_t out_sel;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic sweep_last;
  } status_t;

  // Bin = 64*(red>>5) + 8*(green>>5) + (blue>>5)
  function automatic logic [BIN_W-1:0] bin_of(input logic [CH_W-1:0] red,
                                              input logic [CH_W-1:0] green,
                                              input logic [CH_W-1:0] blue);
    bin_of = {red[CH_W-1 -: CH_KEEP], green[CH_W-1 -: CH_KEEP], blue[CH_W-1 -: CH_KEEP]};
  endfunction

endpackage

`default_nettype wire

// ===== hdl/mrch_ctrl.sv =====
// Controller state machine for the histogram: clear sweep, item sequencing, result slot.
// Depends on mrch_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module mrch_ctrl (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_tvalid,
  output logic                    in_tready,
  input  mrch_pkg::req_t          in_req,
  output logic                    out_tvalid,
  input  wire                     out_tready,
  output mrch_pkg::cmd_t          cmd,
  input  mrch_pkg::status_t       status
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_REPLY
  } state_t;

  state_t         state_r;
  logic           reply_r;
  logic           out_valid_r;
  mrch_pkg::req_t req_r;

  logic accept;
  logic out_free;

  assign accept    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    cmd            = '0;
    cmd.load_item  = accept && (in_req != mrch_pkg::REQ_START);
    cmd.pos_clr    = accept && (in_req == mrch_pkg::REQ_START);
    cmd.clr_step   = (state_r == ST_CLEAR);
    cmd.out_load   = ((state_r == ST_EXEC) || (state_r == ST_REPLY)) && out_free;
    cmd.pix_commit = (state_r == ST_EXEC) && out_free && (req_r == mrch_pkg::REQ_PIXEL);
    cmd.out_sel    = mrch_pkg::RES_ZERO;
    if (state_r == ST_EXEC) begin
      case (req_r)
        mrch_pkg::REQ_PIXEL: cmd.out_sel = mrch_pkg::RES_PIXEL;
        mrch_pkg::REQ_READ:  cmd.out_sel = mrch_pkg::RES_READ;
        default:             cmd.out_sel = mrch_pkg::RES_ZERO;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      reply_r     <= 1'b0;
      out_valid_r <= 1'b0;
      req_r       <= mrch_pkg::REQ_NOP;
    end else begin
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_CLEAR: begin
          if (status.sweep_last) begin
            state_r <= reply_r ? ST_REPLY : ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_tvalid) begin
            req_r <= in_req;
            if (in_req == mrch_pkg::REQ_START) begin
              state_r <= ST_CLEAR;
              reply_r <= 1'b1;
            end else begin
              state_r <= ST_EXEC;
            end
          end
        end
        ST_EXEC, ST_REPLY: begin
          if (out_free) begin
            state_r <= ST_IDLE;
            reply_r <= 1'b0;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  `ASSERT_NEXT(a_start_sweeps, clk, rst_n, accept && (in_req == mrch_pkg::REQ_START), state_r == ST_CLEAR, "start transaction did not enter the clear sweep")
  `ASSERT_ALWAYS(a_no_overwrite, clk, rst_n, !cmd.out_load || !out_valid_r || out_tready, "result register overwritten while still pending")
  `ASSERT_NEXT(a_sweep_blocks_input, clk, rst_n, state_r == ST_CLEAR && !status.sweep_last, !in_tready, "input accepted during clear sweep")

endmodule

`default_nettype wire

// ===== hdl/mrch_dp.sv =====
// Datapath for the histogram: config registers, raster position, bin memory, result register.
// Depends on mrch_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module mrch_dp #(
  parameter int COUNT_BITS = mrch_pkg::COUNT_BITS_DEF,
  parameter int MAX_DIM    = mrch_pkg::MAX_DIM_DEF
) (
  input  wire                                    clk,
  input  wire                                    rst_n,
  input  wire                                    cfg_we,
  input  wire  [mrch_pkg::CFG_ADDR_W-1:0]        cfg_addr,
  input  wire  [mrch_pkg::CFG_DATA_W-1:0]        cfg_wdata,
  input  wire  [mrch_pkg::IN_FIELDS_W-1:0]       in_fields,
  input  mrch_pkg::req_t                         in_req,
  input  mrch_pkg::cmd_t                         cmd,
  output mrch_pkg::status_t                      status,
  output logic [mrch_pkg::BIN_COUNT_W-1:0]       bin_count,
  output logic                                   counted
);

  localparam int POS_W = $clog2(MAX_DIM);
  localparam int CMP_W = ((POS_W > mrch_pkg::IMG_W_W) ? POS_W : mrch_pkg::IMG_W_W) + 1;
  localparam int CH_W  = mrch_pkg::CH_W;
  localparam int BIN_W = mrch_pkg::BIN_W;

  // Configuration
  logic [mrch_pkg::IMG_W_W-1:0] image_width_r;
  logic [mrch_pkg::REG_W-1:0]   region_x_r;
  logic [mrch_pkg::REG_W-1:0]   region_y_r;
  logic [mrch_pkg::REG_W-1:0]   region_w_r;
  logic [mrch_pkg::REG_W-1:0]   region_h_r;

  // Raster position and clear sweep
  logic [POS_W-1:0] col_r;
  logic [POS_W-1:0] row_r;
  logic [BIN_W-1:0] sweep_r;

  // Item and memory
  logic [COUNT_BITS-1:0] mem [mrch_pkg::NUM_BINS];
  logic [COUNT_BITS-1:0] rdata_r;
  logic [BIN_W-1:0]      bin_r;
  logic                  mask_nz_r;

  // Result register
  logic [mrch_pkg::BIN_COUNT_W-1:0] bin_count_r;
  logic                             counted_r;

  logic [CH_W-1:0]       blue, green, red, mask_value;
  logic [BIN_W-1:0]      read_index;
  logic [BIN_W-1:0]      rd_addr;
  logic [COUNT_BITS-1:0] inc;
  logic [CMP_W-1:0]      eff_w;
  logic [CMP_W-1:0]      col_ext, row_ext, col_inc;
  logic                  in_region;
  logic                  hit;
  logic                  wr_en;
  logic [BIN_W-1:0]      wr_addr;
  logic [COUNT_BITS-1:0] wr_data;

  assign blue       = in_fields[0*CH_W +: CH_W];
  assign green      = in_fields[1*CH_W +: CH_W];
  assign red        = in_fields[2*CH_W +: CH_W];
  assign mask_value = in_fields[3*CH_W +: CH_W];
  assign read_index = in_fields[4*CH_W +: BIN_W];

  assign rd_addr = (in_req == mrch_pkg::REQ_READ) ? read_index
                                                   : mrch_pkg::bin_of(red, green, blue);

  // Width of 0 acts as 1; above MAX_DIM acts as MAX_DIM
  always_comb begin
    eff_w = CMP_W'(image_width_r);
    if (image_width_r == '0) begin
      eff_w = CMP_W'(1);
    end else if (eff_w > CMP_W'(MAX_DIM)) begin
      eff_w = CMP_W'(MAX_DIM);
    end
  end

  assign col_ext = CMP_W'(col_r);
  assign row_ext = CMP_W'(row_r);
  assign col_inc = col_ext + CMP_W'(1);

  assign in_region = (CMP_W'(region_y_r) <= row_ext) &&
                     (row_ext <= CMP_W'(region_y_r) + CMP_W'(region_h_r)) &&
                     (CMP_W'(region_x_r) <= col_ext) &&
                     (col_ext <= CMP_W'(region_x_r) + CMP_W'(region_w_r));
  assign hit = in_region && mask_nz_r;
  assign inc = rdata_r + COUNT_BITS'(1);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = bin_r;
    wr_data = inc;
    if (cmd.clr_step) begin
      wr_en   = 1'b1;
      wr_addr = sweep_r;
      wr_data = '0;
    end else if (cmd.pix_commit && hit) begin
      wr_en = 1'b1;
    end
  end

  assign status.sweep_last = (sweep_r == BIN_W'(mrch_pkg::NUM_BINS - 1));
  assign bin_count = bin_count_r;
  assign counted   = counted_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r <= mrch_pkg::IMG_W_RESET;
      region_x_r    <= '0;
      region_y_r    <= '0;
      region_w_r    <= mrch_pkg::REGION_RESET;
      region_h_r    <= mrch_pkg::REGION_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        mrch_pkg::CFG_IMAGE_WIDTH:   image_width_r <= cfg_wdata;
        mrch_pkg::CFG_REGION_X:      region_x_r    <= cfg_wdata[mrch_pkg::REG_W-1:0];
        mrch_pkg::CFG_REGION_Y:      region_y_r    <= cfg_wdata[mrch_pkg::REG_W-1:0];
        mrch_pkg::CFG_REGION_WIDTH:  region_w_r    <= cfg_wdata[mrch_pkg::REG_W-1:0];
        mrch_pkg::CFG_REGION_HEIGHT: region_h_r    <= cfg_wdata[mrch_pkg::REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      sweep_r <= '0;
    end else begin
      if (cmd.clr_step) begin
        sweep_r <= sweep_r + BIN_W'(1);
      end
      if (cmd.pos_clr) begin
        col_r <= '0;
        row_r <= '0;
      end else if (cmd.pix_commit) begin
        // Wrap the column at the row end, then advance the row modulo MAX_DIM
        if (col_inc >= eff_w) begin
          col_r <= '0;
          row_r <= (row_r == POS_W'(MAX_DIM - 1)) ? '0 : row_r + POS_W'(1);
        end else begin
          col_r <= col_inc[POS_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.load_item) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      bin_r     <= mrch_pkg::bin_of(red, green, blue);
      mask_nz_r <= (mask_value != '0);
    end
    if (cmd.out_load) begin
      case (cmd.out_sel)
        mrch_pkg::RES_PIXEL: begin
          bin_count_r <= mrch_pkg::BIN_COUNT_W'(hit ? inc : rdata_r);
          counted_r   <= hit;
        end
        mrch_pkg::RES_READ: begin
          bin_count_r <= mrch_pkg::BIN_COUNT_W'(rdata_r);
          counted_r   <= 1'b0;
        end
        default: begin
          bin_count_r <= '0;
          counted_r   <= 1'b0;
        end
      endcase
    end
  end

  `ASSERT_ALWAYS(a_one_writer, clk, rst_n, !(cmd.clr_step && cmd.pix_commit), "clear sweep and pixel write-back collide")
  `ASSERT_NEXT(a_sweep_wraps, clk, rst_n, cmd.clr_step && status.sweep_last, sweep_r == '0, "sweep address did not return to zero")
  `ASSERT_NEXT(a_pos_cleared, clk, rst_n, cmd.pos_clr, (col_r == '0) && (row_r == '0) && !cmd.pix_commit, "raster position not cleared by start")

endmodule

`default_nettype wire

// ===== hdl/masked_region_color_histogram.sv =====
// Top level of the masked region color histogram: ports, controller and datapath.
// Depends on mrch_pkg, mrch_ctrl and mrch_dp.
//
//  channel | ports                      | contents
//  --------+----------------------------+-----------------------------------------
//  in      | in_tvalid/in_tready        | tuser: req_type; tdata: pixel, mask, index
//  out     | out_tvalid/out_tready      | tuser: counted; tdata: bin_count
//  cfg     | cfg_we/cfg_addr/cfg_wdata  | register write, no read-back
//
// A pixel, read or idle request reads its bin when accepted: the bin memory has one
// registered read port, and a pixel hit is written back from the execute state.
// A start request, after its accept cycle, zeroes each bin of the 512-entry memory
// in a clear sweep and then loads its result.
// After reset the same clear sweep runs before the first item is accepted.
// One finished result waits in the output register; a stalled output holds the
// next item in its write-back cycle until the register frees up.
`default_nettype none

module masked_region_color_histogram #(
  parameter int COUNT_BITS = mrch_pkg::COUNT_BITS_DEF,
  parameter int MAX_DIM    = mrch_pkg::MAX_DIM_DEF
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 cfg_we,
  input  wire  [mrch_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  wire  [mrch_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  wire                                 in_tvalid,
  output logic                                in_tready,
  // [7:0] blue, [15:8] green, [23:16] red, [31:24] mask_value, [40:32] read_index
  input  wire  [mrch_pkg::IN_TDATA_W-1:0]     in_tdata,
  // [1:0] req_type
  input  wire  [mrch_pkg::REQ_W-1:0]          in_tuser,
  output logic                                out_tvalid,
  input  wire                                 out_tready,
  // [15:0] bin_count
  output logic [mrch_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // [0] counted
  output logic                                out_tuser
);

  mrch_pkg::cmd_t    cmd;
  mrch_pkg::status_t status;
  mrch_pkg::req_t    in_req;

  assign in_req = mrch_pkg::req_t'(in_tuser);

  mrch_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_req     (in_req),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .status     (status)
  );

  mrch_dp #(
    .COUNT_BITS (COUNT_BITS),
    .MAX_DIM    (MAX_DIM)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_fields (in_tdata[mrch_pkg::IN_FIELDS_W-1:0]),
    .in_req    (in_req),
    .cmd       (cmd),
    .status    (status),
    .bin_count (out_tdata),
    .counted   (out_tuser)
  );

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking regression for masked_region_color_histogram: directed, limit and random tests.
// Depends on mrch_pkg and the RTL; keeps its own histogram and raster position to predict results.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import mrch_pkg::*;

  typedef struct packed {
    logic [BIN_COUNT_W-1:0] count;
    logic                   hit;
  } hist_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_addr = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [REQ_W-1:0]       in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;

  masked_region_color_histogram dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  // Mirror of the block's state and registers
  logic [BIN_COUNT_W-1:0] hist_bins [NUM_BINS];
  logic [REG_W-1:0]       col_now, row_now;
  logic [IMG_W_W-1:0]     reg_img_w;
  logic [REG_W-1:0]       reg_x, reg_y, reg_rw, reg_rh;

  hist_result_t pending_counts[$];
  hist_result_t head;
  int           mismatches = 0;
  bit           send_gaps_on = 1'b1;
  bit           recv_stalls_on = 1'b1;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("masked_region_color_histogram regression: fail");
    $finish;
  end

  function automatic hist_result_t histogram_step(input req_t req,
                                                  input logic [7:0] red, green, blue, mask,
                                                  input logic [BIN_W-1:0] idx);
    hist_result_t     res;
    logic [BIN_W-1:0] bin;
    logic [12:0]      right_edge, bottom_edge, eff_w;
    logic             in_rect;
    res = '0;
    case (req)
      REQ_START: begin
        foreach (hist_bins[i]) hist_bins[i] = '0;
        col_now = '0;
        row_now = '0;
      end
      REQ_PIXEL: begin
        bin = BIN_W'((red >> 5) * 64 + (green >> 5) * 8 + (blue >> 5));
        // edges are formed at 13 bits so they never wrap
        right_edge  = 13'(reg_x) + 13'(reg_rw);
        bottom_edge = 13'(reg_y) + 13'(reg_rh);
        in_rect = (row_now >= reg_y) && (13'(row_now) <= bottom_edge) &&
                  (col_now >= reg_x) && (13'(col_now) <= right_edge);
        if (in_rect && mask != 8'd0) begin
          hist_bins[bin] = hist_bins[bin] + 1'b1;
          res.hit = 1'b1;
        end
        res.count = hist_bins[bin];
        // a zero width acts as one, anything above the maximum as the maximum
        if (reg_img_w == '0) eff_w = 13'd1;
        else if (reg_img_w > 13'(MAX_DIM_DEF)) eff_w = 13'(MAX_DIM_DEF);
        else eff_w = reg_img_w;
        if (13'(col_now) + 13'd1 >= eff_w) begin
          col_now = '0;
          row_now = row_now + 1'b1;
        end else begin
          col_now = col_now + 1'b1;
        end
      end
      REQ_READ: res.count = hist_bins[idx];
      default: ;
    endcase
    return res;
  endfunction

  // Drive one request and hold it until the block takes it
  task automatic send_item(input req_t req, input logic [7:0] red, green, blue, mask,
                           input logic [BIN_W-1:0] idx);
    int gap;
    gap = send_gaps_on ? $urandom_range(0, 12) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_TDATA_W'({idx, mask, red, green, blue});
    in_tuser  <= req;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_counts.push_back(histogram_step(req, red, green, blue, mask, idx));
  endtask

  task automatic hold_until_drained();
    in_tvalid <= 1'b0;
    while (pending_counts.size() != 0) @(posedge clk);
  endtask

  // Write all five registers once the block has gone quiet and any clear sweep has finished
  task automatic apply_config(input logic [IMG_W_W-1:0] w, input logic [REG_W-1:0] x, y, rw, rh);
    hold_until_drained();
    repeat (600) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_IMAGE_WIDTH;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_addr  <= CFG_REGION_X;
    cfg_wdata <= CFG_DATA_W'(x);
    @(posedge clk);
    cfg_addr  <= CFG_REGION_Y;
    cfg_wdata <= CFG_DATA_W'(y);
    @(posedge clk);
    cfg_addr  <= CFG_REGION_WIDTH;
    cfg_wdata <= CFG_DATA_W'(rw);
    @(posedge clk);
    cfg_addr  <= CFG_REGION_HEIGHT;
    cfg_wdata <= CFG_DATA_W'(rh);
    @(posedge clk);
    cfg_we    <= 1'b0;
    reg_img_w = w;
    reg_x     = x;
    reg_y     = y;
    reg_rw    = rw;
    reg_rh    = rh;
  endtask

  // Result channel: random stall before each transaction
  initial begin
    int stall;
    while (!rst_n) @(posedge clk);
    forever begin
      stall = recv_stalls_on ? $urandom_range(0, 12) : 0;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_counts.size() == 0) begin
        if (mismatches < 200)
          $display("%0t: result with nothing expected: expected none, actual count %0d counted %0b",
                   $time, out_tdata, out_tuser);
        mismatches++;
      end else begin
        head = pending_counts.pop_front();
        if (out_tdata !== head.count) begin
          if (mismatches < 200)
            $display("%0t: bin_count mismatch: expected %0d, actual %0d",
                     $time, head.count, out_tdata);
          mismatches++;
        end
        if (out_tuser !== head.hit) begin
          if (mismatches < 200)
            $display("%0t: counted mismatch: expected %0b, actual %0b",
                     $time, head.hit, out_tuser);
          mismatches++;
        end
      end
    end
  end

  // Extremes of every field, every request code, mask on and off
  task automatic test_directed();
    send_item(REQ_PIXEL, 8'h00, 8'h00, 8'h00, 8'h01, 9'd0);
    send_item(REQ_PIXEL, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 9'h1FF);
    send_item(REQ_PIXEL, 8'hFF, 8'hFF, 8'hFF, 8'h80, 9'h155);
    send_item(REQ_PIXEL, 8'hFF, 8'hFF, 8'hFF, 8'h00, 9'h0AA);
    send_item(REQ_PIXEL, 8'hE0, 8'h1F, 8'hA5, 8'h00, 9'd0);
    send_item(REQ_PIXEL, 8'h1F, 8'hE0, 8'h5A, 8'h7F, 9'd0);
    send_item(REQ_READ,  8'hFF, 8'hFF, 8'hFF, 8'hFF, 9'd0);
    send_item(REQ_READ,  8'h00, 8'h00, 8'h00, 8'h00, 9'h1FF);
    send_item(REQ_READ,  8'h00, 8'h00, 8'h00, 8'h00, 9'h155);
    send_item(REQ_READ,  8'h00, 8'h00, 8'h00, 8'h00, 9'h0AA);
    send_item(REQ_NOP,   8'hFF, 8'hFF, 8'hFF, 8'hFF, 9'h1FF);
    send_item(REQ_NOP,   8'h00, 8'h00, 8'h00, 8'h00, 9'd0);
    send_item(REQ_READ,  8'h00, 8'h00, 8'h00, 8'h00, 9'h1FF);
    send_item(REQ_START, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 9'h1FF);
    send_item(REQ_READ,  8'h00, 8'h00, 8'h00, 8'h00, 9'h1FF);
    send_item(REQ_PIXEL, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 9'd0);
    send_item(REQ_READ,  8'h00, 8'h00, 8'h00, 8'h00, 9'h1FF);
    send_item(REQ_START, 8'h00, 8'h00, 8'h00, 8'h00, 9'd0);
  endtask

  // Small image with a rectangle whose edges all fall inside it
  task automatic test_region_edges();
    apply_config(13'd8, 12'd2, 12'd1, 12'd3, 12'd2);
    send_item(REQ_START, 8'h00, 8'h00, 8'h00, 8'h00, 9'd0);
    repeat (44) send_item(REQ_PIXEL, 8'($urandom_range(0, 95)), 8'($urandom),
                          8'($urandom), 8'hFF, 9'd0);
  endtask

  // Width of zero acts as one; width above the maximum acts as the maximum
  task automatic test_width_limits();
    apply_config(13'd0, 12'd0, 12'd2, 12'd4095, 12'd0);
    send_item(REQ_START, 8'h00, 8'h00, 8'h00, 8'h00, 9'd0);
    repeat (8) send_item(REQ_PIXEL, 8'h40, 8'h40, 8'h40, 8'h01, 9'd0);
    apply_config(13'h1FFF, 12'd0, 12'd0, 12'd40, 12'd0);
    send_item(REQ_START, 8'h00, 8'h00, 8'h00, 8'h00, 9'd0);
    send_gaps_on   = 1'b0;
    recv_stalls_on = 1'b0;
    repeat (64) send_item(REQ_PIXEL, 8'($urandom_range(0, 63)), 8'($urandom_range(0, 63)),
                          8'($urandom), 8'($urandom_range(1, 255)), 9'd0);
    send_gaps_on   = 1'b1;
    recv_stalls_on = 1'b1;
  endtask

  // Pile many hits into one bin; width one advances the row on every pixel
  task automatic test_one_bin();
    apply_config(13'd1, 12'd0, 12'd0, 12'd4095, 12'd4095);
    send_item(REQ_START, 8'h00, 8'h00, 8'h00, 8'h00, 9'd0);
    send_gaps_on   = 1'b0;
    recv_stalls_on = 1'b0;
    repeat (200) send_item(REQ_PIXEL, {3'b101, 5'($urandom)}, {3'b010, 5'($urandom)},
                           {3'b110, 5'($urandom)}, 8'($urandom_range(1, 255)), 9'd0);
    send_item(REQ_READ, 8'h00, 8'h00, 8'h00, 8'h00, 9'b101_010_110);
    send_gaps_on   = 1'b1;
    recv_stalls_on = 1'b1;
  endtask

  // Random mix of requests over several register settings
  task automatic test_random();
    int          roll;
    logic [7:0]  red, green, blue, mask;
    logic [8:0]  idx;
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: apply_config(IMG_W_RESET, 12'd0, 12'd0, REGION_RESET, REGION_RESET);
        1: apply_config(13'd1, 12'd0, 12'($urandom_range(0, 20)), 12'd0,
                        12'($urandom_range(0, 10)));
        2: apply_config(13'(MAX_DIM_DEF), 12'd4095, 12'd4095, 12'd4095, 12'd4095);
        default: apply_config(13'($urandom_range(1, 16)), 12'($urandom_range(0, 15)),
                              12'($urandom_range(0, 12)), 12'($urandom_range(0, 8)),
                              12'($urandom_range(0, 8)));
      endcase
      send_gaps_on   = (p != 3);
      recv_stalls_on = (p != 3);
      for (int n = 0; n < 190; n++) begin
        if (n == 95) hold_until_drained();
        roll = $urandom_range(0, 99);
        // half the pixels fall in a few bins so counts climb
        if ($urandom_range(0, 1)) begin
          red   = 8'($urandom_range(0, 63));
          green = 8'($urandom_range(0, 63));
        end else begin
          red   = 8'($urandom);
          green = 8'($urandom);
        end
        blue = 8'($urandom);
        mask = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
        idx  = $urandom_range(0, 1) ? 9'($urandom_range(0, 15)) : 9'($urandom);
        if (roll < 4) send_item(REQ_START, red, green, blue, mask, idx);
        else if (roll < 9) send_item(REQ_NOP, red, green, blue, mask, idx);
        else if (roll < 30) send_item(REQ_READ, red, green, blue, mask, idx);
        else send_item(REQ_PIXEL, red, green, blue, mask, idx);
      end
    end
  endtask

  initial begin
    foreach (hist_bins[i]) hist_bins[i] = '0;
    col_now   = '0;
    row_now   = '0;
    reg_img_w = IMG_W_RESET;
    reg_x     = '0;
    reg_y     = '0;
    reg_rw    = REGION_RESET;
    reg_rh    = REGION_RESET;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_region_edges();
    test_width_limits();
    test_one_bin();
    test_random();
    hold_until_drained();
    repeat (600) @(posedge clk);
    if (mismatches == 0) begin
      $display("masked_region_color_histogram regression: pass");
    end else begin
      $display("masked_region_color_histogram regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
